@@ src/nph_pkg.sv @@
package nph_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int SQ_WIDTH    = 64;
  localparam int ID_WIDTH    = 5;
  localparam int SYM_AW      = 2;
  localparam int PAIR_AW     = 2 * SYM_AW;
  localparam int NUM_SYMBOLS = 1 << SYM_AW;
  localparam int NUM_PAIRS   = 1 << PAIR_AW;
  localparam int SQ_HALF     = SQ_WIDTH / 2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_A       = 8'h61;
  localparam logic [7:0] CHAR_C       = 8'h63;
  localparam logic [7:0] CHAR_T       = 8'h74;
  localparam logic [7:0] CHAR_G       = 8'h67;
  localparam logic [7:0] CASE_FOLD    = 8'h20;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SQ_WIDTH-1:0]    sq_t;
  typedef logic [ID_WIDTH-1:0]    rec_id_t;
  typedef logic [SYM_AW-1:0]      sym_code_t;
  typedef logic [PAIR_AW-1:0]     pair_idx_t;

  localparam sym_code_t SYM_A = 2'd0;
  localparam sym_code_t SYM_C = 2'd1;
  localparam sym_code_t SYM_T = 2'd2;
  localparam sym_code_t SYM_G = 2'd3;

  localparam rec_id_t REC_SYM_FIRST  = 5'd0;
  localparam rec_id_t REC_SYM_LAST   = 5'd3;
  localparam rec_id_t REC_PAIR_FIRST = 5'd4;
  localparam rec_id_t REC_PAIR_LAST  = 5'd19;
  localparam rec_id_t REC_LINES      = 5'd20;
  localparam rec_id_t REC_LEN_SUM    = 5'd21;
  localparam rec_id_t REC_SQ_SUM     = 5'd22;
  localparam rec_id_t REC_LAST       = REC_SQ_SUM;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] report_id;
    logic [SQ_WIDTH-1:0] report_value;
    logic                report_last;
  } report_item_t;

  typedef struct packed {
    logic      hit;
    sym_code_t code;
  } sym_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_REPORT,
    ST_FLUSH
  } nph_state_t;

  function automatic sym_t decode_symbol(logic [7:0] b);
    sym_t s;
    s.hit  = 1'b1;
    s.code = SYM_A;
    unique case (b | CASE_FOLD)
      CHAR_A: s.code = SYM_A;
      CHAR_C: s.code = SYM_C;
      CHAR_T: s.code = SYM_T;
      CHAR_G: s.code = SYM_G;
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

@@ src/nucleotide_pair_histogram.sv @@
// A counting request updates its counter memories in the cycle after acceptance.
// Throughput: one text byte per cycle while in RUN, set by the read-modify-write loop of the
// symbol and pair memories, closed by forwarding of the last write.
// After an end-marked request the FSM passes DRAIN into REPORT, which fetches the 23 records in
// order, one per cycle while report_ready holds, and input stalls while they are fetched.
// Reset (rst, synchronous) clears control, valid bits and totals at once; no clearing pass.
module nucleotide_pair_histogram (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_ready,
  input  nph_pkg::text_item_t   text,
  output logic                  report_valid,
  input  logic                  report_ready,
  output nph_pkg::report_item_t report
);

  function automatic nph_pkg::count_t sat_inc(nph_pkg::count_t v);
    return (&v) ? v : v + nph_pkg::count_t'(1);
  endfunction

  function automatic nph_pkg::count_t sat_add(nph_pkg::count_t v, nph_pkg::count_t a);
    logic [nph_pkg::COUNT_WIDTH:0] s;
    s = {1'b0, v} + {1'b0, a};
    return s[nph_pkg::COUNT_WIDTH] ? '1 : s[nph_pkg::COUNT_WIDTH-1:0];
  endfunction

  // Control state
  nph_pkg::nph_state_t state, state_next;
  nph_pkg::rec_id_t    rep_k;
  logic                rep_issue;
  logic                f_valid;
  nph_pkg::rec_id_t    f_id;
  logic                f_move;
  logic                clear;

  // Decode of the incoming request
  logic                accept;
  logic                is_nl;
  nph_pkg::sym_t       cur_sym;
  logic                sym_hit;
  logic                pair_hit;

  // Pairing and line tracking
  logic                 pair_phase;
  logic                 pend_valid;
  nph_pkg::sym_code_t   pend_code;
  nph_pkg::count_t      cur_len;
  nph_pkg::count_t      line_total;
  nph_pkg::count_t      length_sum;

  // Square pipeline
  logic [nph_pkg::SQ_WIDTH-1:0] len_wide;
  logic [nph_pkg::SQ_HALF-1:0]  len_lo;
  logic                         sq_v;
  logic                         sq_big;
  nph_pkg::sq_t                 sq_prod;
  nph_pkg::sq_t                 sq_sum;
  logic [nph_pkg::SQ_WIDTH:0]   sq_add;

  // Symbol counter memory
  nph_pkg::count_t    sym_mem [nph_pkg::NUM_SYMBOLS];
  logic [nph_pkg::NUM_SYMBOLS-1:0] sym_ok;
  nph_pkg::sym_code_t sym_raddr;
  logic               sym_rd_en;
  nph_pkg::count_t    sym_rd_data;
  logic               sym_rd_ok;
  nph_pkg::count_t    sym_rd_val;
  logic               s1_sym_v;
  nph_pkg::sym_code_t s1_sym_addr;
  logic               sym_lw_v;
  nph_pkg::sym_code_t sym_lw_addr;
  nph_pkg::count_t    sym_lw_data;
  nph_pkg::count_t    sym_new;

  // Pair counter memory
  nph_pkg::count_t    pair_mem [nph_pkg::NUM_PAIRS];
  logic [nph_pkg::NUM_PAIRS-1:0] pair_ok;
  nph_pkg::pair_idx_t pair_raddr;
  nph_pkg::rec_id_t   pair_rec_off;
  logic               pair_rd_en;
  nph_pkg::count_t    pair_rd_data;
  logic               pair_rd_ok;
  nph_pkg::count_t    pair_rd_val;
  logic               s1_pair_v;
  nph_pkg::pair_idx_t s1_pair_addr;
  logic               pair_lw_v;
  nph_pkg::pair_idx_t pair_lw_addr;
  nph_pkg::count_t    pair_lw_data;
  nph_pkg::count_t    pair_new;

  logic [nph_pkg::SQ_WIDTH-1:0] rep_value;

  // Request decode: a nucleotide always bumps its symbol counter, and closes a pair
  // when one is pending from the byte before.
  assign accept   = text_valid && text_ready;
  assign is_nl    = (text.text_byte == nph_pkg::CHAR_NEWLINE);
  assign cur_sym  = nph_pkg::decode_symbol(text.text_byte);
  assign sym_hit  = accept && !is_nl && cur_sym.hit;
  assign pair_hit = sym_hit && pend_valid;

  // Fetch stage moves into the output register whenever that register is free or drains.
  assign f_move = f_valid && (!report_valid || report_ready);
  assign clear  = (state == nph_pkg::ST_FLUSH) && f_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nph_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // RUN takes requests; DRAIN lets the end request's memory write land;
  // REPORT fetches the records in order; FLUSH waits for the last one to move out.
  always_comb begin
    state_next = state;
    text_ready = 1'b0;
    rep_issue  = 1'b0;
    unique case (state)
      nph_pkg::ST_RUN: begin
        text_ready = 1'b1;
        if (text_valid && text.end_of_text) begin
          state_next = nph_pkg::ST_DRAIN;
        end
      end
      nph_pkg::ST_DRAIN: begin
        state_next = nph_pkg::ST_REPORT;
      end
      nph_pkg::ST_REPORT: begin
        rep_issue = !f_valid || f_move;
        if (rep_issue && rep_k == nph_pkg::REC_LAST) begin
          state_next = nph_pkg::ST_FLUSH;
        end
      end
      nph_pkg::ST_FLUSH: begin
        if (f_move) begin
          state_next = nph_pkg::ST_RUN;
        end
      end
      default: state_next = nph_pkg::ST_RUN;
    endcase
  end

  // Report record counter and fetch stage
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      rep_k   <= '0;
      f_valid <= 1'b0;
    end else if (rep_issue) begin
      rep_k   <= rep_k + nph_pkg::rec_id_t'(1);
      f_valid <= 1'b1;
    end else if (f_move) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rep_issue) begin
      f_id <= rep_k;
    end
  end

  // Pairing phase, pending symbol and line statistics
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pair_phase <= 1'b0;
      pend_valid <= 1'b0;
      cur_len    <= '0;
      line_total <= '0;
      length_sum <= '0;
    end else if (accept) begin
      // Drop any pending symbol; only an even-phase nucleotide with nothing
      // pending starts a new pair.
      pend_valid <= sym_hit && !pend_valid && !pair_phase;
      if (is_nl) begin
        line_total <= sat_inc(line_total);
        length_sum <= sat_add(length_sum, cur_len);
        cur_len    <= '0;
      end else begin
        cur_len    <= sat_inc(cur_len);
        pair_phase <= ~pair_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_code <= cur_sym.code;
    end
  end

  // Squared length: multiply in one stage, accumulate with saturation in the next.
  assign len_wide = nph_pkg::SQ_WIDTH'(cur_len);
  assign len_lo   = len_wide[nph_pkg::SQ_HALF-1:0];
  assign sq_add   = {1'b0, sq_sum} + {1'b0, sq_prod};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sq_v   <= 1'b0;
      sq_sum <= '0;
    end else begin
      sq_v <= accept && is_nl;
      if (sq_v) begin
        sq_sum <= (sq_big || sq_add[nph_pkg::SQ_WIDTH]) ? '1
                                                         : sq_add[nph_pkg::SQ_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_nl) begin
      sq_big  <= |len_wide[nph_pkg::SQ_WIDTH-1:nph_pkg::SQ_HALF];
      sq_prod <= len_lo * len_lo;
    end
  end

  // Memory read addresses: the report sweep owns the ports in REPORT.
  assign pair_rec_off = rep_k - nph_pkg::REC_PAIR_FIRST;
  assign sym_raddr  = (state == nph_pkg::ST_REPORT) ? rep_k[nph_pkg::SYM_AW-1:0]
                                                    : cur_sym.code;
  assign pair_raddr = (state == nph_pkg::ST_REPORT) ? pair_rec_off[nph_pkg::PAIR_AW-1:0]
                                                    : {pend_code, cur_sym.code};
  assign sym_rd_en  = sym_hit || rep_issue;
  assign pair_rd_en = pair_hit || rep_issue;

  // An entry never written since reset or the last report reads as zero.
  assign sym_rd_val  = sym_rd_ok ? sym_rd_data : '0;
  assign pair_rd_val = pair_rd_ok ? pair_rd_data : '0;

  // Forward the previous write when it hit the entry that was read under it.
  assign sym_new  = sat_inc((sym_lw_v && sym_lw_addr == s1_sym_addr) ? sym_lw_data
                                                                      : sym_rd_val);
  assign pair_new = sat_inc((pair_lw_v && pair_lw_addr == s1_pair_addr) ? pair_lw_data
                                                                          : pair_rd_val);

  always_ff @(posedge clk) begin
    if (sym_rd_en) begin
      sym_rd_data <= sym_mem[sym_raddr];
    end
    if (s1_sym_v) begin
      sym_mem[s1_sym_addr] <= sym_new;
    end
    if (pair_rd_en) begin
      pair_rd_data <= pair_mem[pair_raddr];
    end
    if (s1_pair_v) begin
      pair_mem[s1_pair_addr] <= pair_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s1_sym_v   <= 1'b0;
      s1_pair_v  <= 1'b0;
      sym_lw_v   <= 1'b0;
      pair_lw_v  <= 1'b0;
      sym_ok     <= '0;
      pair_ok    <= '0;
      sym_rd_ok  <= 1'b0;
      pair_rd_ok <= 1'b0;
    end else begin
      s1_sym_v  <= sym_hit;
      s1_pair_v <= pair_hit;
      if (sym_rd_en) begin
        sym_rd_ok <= sym_ok[sym_raddr];
      end
      if (pair_rd_en) begin
        pair_rd_ok <= pair_ok[pair_raddr];
      end
      if (s1_sym_v) begin
        sym_lw_v            <= 1'b1;
        sym_ok[s1_sym_addr] <= 1'b1;
      end
      if (s1_pair_v) begin
        pair_lw_v             <= 1'b1;
        pair_ok[s1_pair_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sym_hit) begin
      s1_sym_addr <= cur_sym.code;
    end
    if (pair_hit) begin
      s1_pair_addr <= {pend_code, cur_sym.code};
    end
    if (s1_sym_v) begin
      sym_lw_addr <= s1_sym_addr;
      sym_lw_data <= sym_new;
    end
    if (s1_pair_v) begin
      pair_lw_addr <= s1_pair_addr;
      pair_lw_data <= pair_new;
    end
  end

  // Select the record value for the fetch stage.
  always_comb begin
    case (f_id) inside
      [nph_pkg::REC_SYM_FIRST:nph_pkg::REC_SYM_LAST]:
        rep_value = nph_pkg::SQ_WIDTH'(sym_rd_val);
      [nph_pkg::REC_PAIR_FIRST:nph_pkg::REC_PAIR_LAST]:
        rep_value = nph_pkg::SQ_WIDTH'(pair_rd_val);
      nph_pkg::REC_LINES:   rep_value = nph_pkg::SQ_WIDTH'(line_total);
      nph_pkg::REC_LEN_SUM: rep_value = nph_pkg::SQ_WIDTH'(length_sum);
      nph_pkg::REC_SQ_SUM:  rep_value = sq_sum;
      default:              rep_value = '0;
    endcase
  end

  // Output register: hold the record until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (f_move) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_move) begin
      report.report_id    <= f_id;
      report.report_value <= rep_value;
      report.report_last  <= (f_id == nph_pkg::REC_LAST);
    end
  end

`ifndef SYNTH
  a_end_stalls_input: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && text.end_of_text |=> !text_ready)
    else $error("input still accepted after an end request");

  a_last_is_final_record: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.report_last |-> report.report_id == nph_pkg::REC_LAST)
    else $error("last flag on a record other than the final one");

  a_no_update_during_report: assert property (@(posedge clk) disable iff (rst)
    state == nph_pkg::ST_REPORT |-> !s1_sym_v && !s1_pair_v && !sq_v)
    else $error("counter update still in flight during the report");

  a_pending_odd_phase: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pair_phase)
    else $error("pending symbol held in even phase");

  a_fetch_in_range: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> f_id <= nph_pkg::REC_LAST)
    else $error("report fetch beyond the final record");
`endif

endmodule
